@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/ocsb_pkg.sv @@
`default_nettype none

package ocsb_pkg;

  localparam logic [1:0] OP_STAMP = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // wide enough to hold the word count of the largest store
  localparam int ADDR_LIM_W = 17;

  typedef struct packed {
    logic [1:0]  operation;
    logic [9:0]  center_x;
    logic [8:0]  center_y;
    logic        large_req;
    logic        draw;
    logic [13:0] word_addr;
    logic [31:0] write_data;
  } ocsb_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        status;
  } ocsb_out_t;

  function automatic logic [31:0] small_mask(input logic [4:0] idx);
    logic [31:0] m;
    case (idx)
      5'd0, 5'd16:                       m = 32'h00010000;
      5'd1, 5'd15:                       m = 32'h000FE000;
      5'd2, 5'd14:                       m = 32'h003FF800;
      5'd3, 5'd4, 5'd12, 5'd13:          m = 32'h007FFC00;
      5'd5, 5'd6, 5'd7, 5'd9, 5'd10, 5'd11: m = 32'h00FFFE00;
      5'd8:                              m = 32'h01FFFF00;
      default:                           m = 32'h00000000;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] large_mask(input logic [4:0] idx);
    logic [31:0] m;
    case (idx)
      5'd0, 5'd30:                       m = 32'h00010000;
      5'd1, 5'd29:                       m = 32'h003FF800;
      5'd2, 5'd28:                       m = 32'h00FFFE00;
      5'd3, 5'd27:                       m = 32'h01FFFF00;
      5'd4, 5'd26:                       m = 32'h07FFFFC0;
      5'd5, 5'd6, 5'd24, 5'd25:          m = 32'h0FFFFFE0;
      5'd7, 5'd23:                       m = 32'h1FFFFFF0;
      5'd8, 5'd9, 5'd21, 5'd22:          m = 32'h3FFFFFF8;
      5'd10, 5'd11, 5'd12, 5'd13, 5'd14,
      5'd16, 5'd17, 5'd18, 5'd19, 5'd20: m = 32'h7FFFFFFC;
      5'd15:                             m = 32'hFFFFFFFE;
      default:                           m = 32'h00000000;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/ocsb_ram.sv @@
`default_nettype none

module ocsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/one_bit_circle_stamp_blitter.sv @@
// One-bit circle stamp blitter: a 1-bit-per-pixel frame store of 32-bit words
// (LINE_WORDS words per line, FB_LINES lines, leftmost pixel in the msb).
// Input channel in_valid/in_ready/in_item carries one operation per item:
// stamp a small or large filled circle (set or clear), write a word, read a
// word. Result channel out_valid/out_ready/out_item returns exactly one item
// per input item: the word read (zero otherwise) and a reject status for
// stamps whose rows or left edge fall outside the store or whose mask runs past its end.
// After reset a clearing pass writes zero to every one of the LINE_WORDS*FB_LINES
// words (10240 by default), one word a cycle; in_ready stays low meanwhile.
// Steps per item: every item passes DECODE and ends in HOLD, which loads the
// output register once it is free; a read in range adds RDWAIT between them,
// and an accepted stamp adds STAMP, which reads and writes each mask word in
// turn (two words a row when the mask spans two words, one when it is word
// aligned; rows is 17 or 31), then DRAIN. The next item is taken in IDLE.
// The single frame memory port pair sets the stamp pace: each mask word is read,
// then written back in the cycle after, overlapped with the read of the next word.
// The block takes one item at a time; in_ready is high only while idle.
// A finished result sits in the output register; the next item may be
// accepted and worked on meanwhile, and its result waits until out_ready
// frees the register.
`default_nettype none

module one_bit_circle_stamp_blitter
  import ocsb_pkg::*;
#(
  parameter int LINE_WORDS = 20,
  parameter int FB_LINES   = 512
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire ocsb_in_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output ocsb_out_t      out_item
);

  `include "assert_macros.svh"

  localparam int STORE_WORDS = LINE_WORDS * FB_LINES;
  localparam int ADDR_W      = $clog2(STORE_WORDS);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_RDWAIT = 3'd3;
  localparam logic [2:0] S_STAMP  = 3'd4;
  localparam logic [2:0] S_DRAIN  = 3'd5;
  localparam logic [2:0] S_HOLD   = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  ocsb_in_t          item_r, item_nxt;
  logic [4:0]        row_r, row_nxt;
  logic              side_r, side_nxt;
  logic [ADDR_W-1:0] row_addr_r, row_addr_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [ADDR_W-1:0] pend_addr_r, pend_addr_nxt;
  logic [31:0]       pend_bits_r, pend_bits_nxt;
  logic [31:0]       res_data_r, res_data_nxt;
  logic              res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  ocsb_out_t         out_item_r, out_item_nxt;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [31:0]           ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [31:0]           ram_rdata;

  logic [8:0]            half;
  logic [4:0]            rows_m1;
  logic [9:0]            left;
  logic [4:0]            col;
  logic [4:0]            sh;
  logic [8:0]            top;
  logic [9:0]            last_line;
  logic                  reject;
  logic [ADDR_LIM_W-1:0] base_full;
  logic [ADDR_LIM_W-1:0] addr_ext;
  logic                  addr_ok;
  logic [31:0]           row_mask;
  logic [63:0]           shifted;
  logic                  last_word;
  logic [ADDR_W-1:0]     cur_addr;
  logic [31:0]           cur_bits;
  logic [31:0]           merged;

  // stamp geometry and range checks
  always_comb begin
    half      = item_r.large_req ? 9'd15 : 9'd8;
    rows_m1   = item_r.large_req ? 5'd30 : 5'd16;
    left      = item_r.center_x - 10'd16;
    col       = left[9:5];
    sh        = left[4:0];
    top       = item_r.center_y - half;
    last_line = {1'b0, top} + {5'd0, rows_m1};
    reject    = (item_r.center_x < 10'd16) || (item_r.center_y < half) ||
                ({2'b0, col} >= 7'(LINE_WORDS)) ||
                ({1'b0, last_line} >= 11'(FB_LINES)) ||
                ((sh != 5'd0) && ({1'b0, last_line} == 11'(FB_LINES - 1)) &&
                 ({2'b0, col} == 7'(LINE_WORDS - 1)));
    base_full = ADDR_LIM_W'(top) * ADDR_LIM_W'(LINE_WORDS) + ADDR_LIM_W'(col);
    addr_ext  = ADDR_LIM_W'(item_r.word_addr);
    addr_ok   = addr_ext < ADDR_LIM_W'(STORE_WORDS);
  end

  // shared shifter: one mask row split across left and right words
  always_comb begin
    row_mask  = item_r.large_req ? large_mask(row_r) : small_mask(row_r);
    shifted   = {row_mask, 32'd0} >> sh;
    cur_bits  = side_r ? shifted[31:0] : shifted[63:32];
    cur_addr  = side_r ? row_addr_r + ADDR_W'(1) : row_addr_r;
    last_word = (row_r == rows_m1) && (side_r || (sh == 5'd0));
    merged    = item_r.draw ? (ram_rdata | pend_bits_r) : (ram_rdata & ~pend_bits_r);
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    item_nxt       = item_r;
    row_nxt        = row_r;
    side_nxt       = side_r;
    row_addr_nxt   = row_addr_r;
    pend_valid_nxt = pend_valid_r;
    pend_addr_nxt  = pend_addr_r;
    pend_bits_nxt  = pend_bits_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_item_nxt   = out_item_r;
    ram_we         = 1'b0;
    ram_waddr      = pend_addr_r;
    ram_wdata      = merged;
    ram_raddr      = addr_ext[ADDR_W-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = 32'd0;
        clr_nxt   = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(STORE_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_item;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        res_data_nxt   = 32'd0;
        res_status_nxt = 1'b0;
        row_nxt        = 5'd0;
        side_nxt       = 1'b0;
        row_addr_nxt   = base_full[ADDR_W-1:0];
        pend_valid_nxt = 1'b0;
        state_nxt      = S_HOLD;
        case (item_r.operation)
          OP_STAMP: begin
            if (reject) begin
              res_status_nxt = 1'b1;
            end else begin
              state_nxt = S_STAMP;
            end
          end
          OP_WRITE: begin
            ram_we    = addr_ok;
            ram_waddr = addr_ext[ADDR_W-1:0];
            ram_wdata = item_r.write_data;
          end
          OP_READ: begin
            if (addr_ok) begin
              state_nxt = S_RDWAIT;
            end
          end
          default: begin
          end
        endcase
      end
      S_RDWAIT: begin
        res_data_nxt = ram_rdata;
        state_nxt    = S_HOLD;
      end
      S_STAMP: begin
        ram_we         = pend_valid_r;
        ram_raddr      = cur_addr;
        pend_valid_nxt = 1'b1;
        pend_addr_nxt  = cur_addr;
        pend_bits_nxt  = cur_bits;
        if (side_r || (sh == 5'd0)) begin
          side_nxt     = 1'b0;
          row_nxt      = row_r + 5'd1;
          row_addr_nxt = row_addr_r + ADDR_W'(LINE_WORDS);
        end else begin
          side_nxt = 1'b1;
        end
        if (last_word) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        ram_we         = 1'b1;
        pend_valid_nxt = 1'b0;
        state_nxt      = S_HOLD;
      end
      S_HOLD: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_item_nxt.read_data = res_data_r;
          out_item_nxt.status    = res_status_r;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    item_r       <= item_nxt;
    row_r        <= row_nxt;
    side_r       <= side_nxt;
    row_addr_r   <= row_addr_nxt;
    pend_addr_r  <= pend_addr_nxt;
    pend_bits_r  <= pend_bits_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
    out_item_r   <= out_item_nxt;
  end

  ocsb_ram #(
    .WIDTH(32),
    .DEPTH(STORE_WORDS)
  ) u_frame (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `ASSERT_NOW(a_no_accept_clear, state_r == S_CLEAR, !in_ready, "item taken during clear")
  `ASSERT_NOW(a_pend_scope, pend_valid_r, state_r == S_STAMP || state_r == S_DRAIN,
              "write-back pending outside stamp")
  `ASSERT_NOW(a_no_rmw_hazard, state_r == S_STAMP && pend_valid_r, pend_addr_r != cur_addr,
              "read of word under write-back")
  `ASSERT_NEXT(a_out_from_hold, !out_valid_r || out_ready,
               !$rose(out_valid_r) || $past(state_r == S_HOLD), "result not from hold")

endmodule

`default_nettype wire
